// ===== sv/sme_pkg.sv =====
package sme_pkg;

	// Default sizes of the word memory and of the program store.
	localparam int MEM_WORDS_DEF  = 4096;
	localparam int PROG_DEPTH_DEF = 1024;

	// Instruction codes.
	localparam logic [6:0] OP_POP   = 7'd0;
	localparam logic [6:0] OP_IPOP  = 7'd1;
	localparam logic [6:0] OP_PUSH  = 7'd2;
	localparam logic [6:0] OP_IPUSH = 7'd3;
	localparam logic [6:0] OP_PUSHI = 7'd4;
	localparam logic [6:0] OP_JMP   = 7'd5;
	localparam logic [6:0] OP_JNZ   = 7'd6;
	localparam logic [6:0] OP_CALL  = 7'd7;
	localparam logic [6:0] OP_RET   = 7'd8;
	localparam logic [6:0] OP_READ  = 7'd9;
	localparam logic [6:0] OP_WRITE = 7'd10;
	localparam logic [6:0] OP_ALU   = 7'd11;
	localparam logic [6:0] OP_RND   = 7'd12;
	localparam logic [6:0] OP_DUP   = 7'd13;
	localparam logic [6:0] OP_NOP   = 7'd98;
	localparam logic [6:0] OP_HALT  = 7'd99;

	// ALU operation codes carried in the operand.
	localparam logic [3:0] ALU_EQ  = 4'd0;
	localparam logic [3:0] ALU_NE  = 4'd1;
	localparam logic [3:0] ALU_GE  = 4'd2;
	localparam logic [3:0] ALU_LE  = 4'd3;
	localparam logic [3:0] ALU_GT  = 4'd4;
	localparam logic [3:0] ALU_LT  = 4'd5;
	localparam logic [3:0] ALU_OR  = 4'd6;
	localparam logic [3:0] ALU_XOR = 4'd7;
	localparam logic [3:0] ALU_AND = 4'd8;
	localparam logic [3:0] ALU_NOT = 4'd9;
	localparam logic [3:0] ALU_ADD = 4'd10;
	localparam logic [3:0] ALU_SUB = 4'd11;
	localparam logic [3:0] ALU_MUL = 4'd12;
	localparam logic [3:0] ALU_DIV = 4'd13;
	localparam logic [3:0] ALU_MOD = 4'd14;
	localparam logic [3:0] ALU_NEG = 4'd15;

	// Status codes reported with every result item.
	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_HALT  = 3'd1,
		STAT_EMPTY = 3'd2,
		STAT_FULL  = 3'd3,
		STAT_ADDR  = 3'd4,
		STAT_DIV0  = 3'd5,
		STAT_OPC   = 3'd6
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RDA,
		S_RDB,
		S_CAPB,
		S_DIV,
		S_EXEC
	} fsm_t;

	typedef struct packed {
		logic [6:0]         instr_opcode;
		logic signed [15:0] instr_operand;
		logic signed [15:0] read_value;
		logic [14:0]        random_value;
	} instr_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic [2:0]         status;
		logic               write_valid;
		logic signed [15:0] write_value;
		logic               finished;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic rd_b;
		logic cap_b;
		logic div_go;
		logic exec;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic div_need;
		logic div_busy;
	} dp_stat_t;

endpackage

// ===== sv/sme_div.sv =====
module sme_div import sme_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] num,
	input  logic [15:0] den,
	output logic [15:0] quo,
	output logic [15:0] rem,
	output logic        busy
);

	logic [4:0]  cnt_q;
	logic [15:0] q_q;
	logic [16:0] r_q;
	logic [16:0] r_sh;

	// One quotient bit per cycle, restoring form.
	assign r_sh = {r_q[15:0], q_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			if (r_sh >= {1'b0, den}) begin
				r_q <= r_sh - {1'b0, den};
				q_q <= {q_q[14:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[14:0], 1'b0};
			end
		end
	end

	assign quo  = q_q;
	assign rem  = r_q[15:0];
	assign busy = (cnt_q != '0);

endmodule

// ===== sv/sme_ctrl.sv =====
module sme_ctrl import sme_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	fsm_t state_q, state_n;
	logic out_valid_q;
	logic fire;

	// An instruction retires once the output register is free or being taken.
	assign fire = (state_q == S_EXEC) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: if (stat.clear_last) state_n = S_IDLE;
			S_IDLE:  if (in_valid) state_n = S_RDA;
			S_RDA:   state_n = S_RDB;
			S_RDB:   state_n = S_CAPB;
			S_CAPB:  state_n = stat.div_need ? S_DIV : S_EXEC;
			S_DIV:   if (!stat.div_busy) state_n = S_EXEC;
			S_EXEC:  if (fire) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE:  cmd.load = in_valid;
			S_RDA:   cmd.load = 1'b0;
			S_RDB:   cmd.rd_b = 1'b1;
			S_CAPB: begin
				cmd.cap_b  = 1'b1;
				cmd.div_go = stat.div_need;
			end
			S_DIV:   cmd.exec = 1'b0;
			S_EXEC:  cmd.exec = fire;
			default: cmd = '0;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== sv/sme_dp.sv =====
module sme_dp import sme_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat,
	input  instr_t     in_data,
	input  logic [10:0] plen,
	output result_t    out_data
);

	localparam int AW  = $clog2(MEM_WORDS);
	localparam int SPW = $clog2(MEM_WORDS + 1);
	localparam logic [16:0] MEMW = 17'(MEM_WORDS);

	logic [15:0] mem [MEM_WORDS];

	logic [6:0]     opc_q;
	logic [15:0]    opd_q;
	logic [15:0]    rdv_q;
	logic [14:0]    rnd_q;
	logic [15:0]    a_q, b_q, rdata_q;
	logic [SPW-1:0] sp_q, sp_n, sp_m1, sp_m2;
	logic [15:0]    pc_q, pc_n, pc_inc, pc_rel;
	logic           stopped_q;
	status_t        held_q, st;
	logic [AW-1:0]  clr_q;
	result_t        out_q;

	logic [AW-1:0]  addr_a, addr_b, raddr, waddr, waddr_x;
	logic [15:0]    wdata, wdata_x;
	logic           we, we_x, wv;
	logic [15:0]    wval;
	logic           running, opd_ok, top_ok, sp_zero, sp_le1, sp_full, is_rnd;
	logic [15:0]    div_num, div_den, dq, dr, quo_s, rem_s, alu_res;
	logic [31:0]    prod;
	logic           div_busy;

	// Latch the instruction item and capture the two words read from memory.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opc_q <= in_data.instr_opcode;
			opd_q <= in_data.instr_operand;
			rdv_q <= in_data.read_value;
			rnd_q <= in_data.random_value;
		end
		if (cmd.rd_b) a_q <= rdata_q;
		if (cmd.cap_b) b_q <= rdata_q;
	end

	// Read addresses: first the top word or the direct address, then the second word
	// or the word that the top points to.
	assign sp_m1  = sp_q - SPW'(1);
	assign sp_m2  = sp_q - SPW'(2);
	assign addr_a = (opc_q == OP_PUSH || opc_q == OP_WRITE) ? opd_q[AW-1:0] : sp_m1[AW-1:0];
	assign addr_b = (opc_q == OP_IPUSH) ? rdata_q[AW-1:0] : sp_m2[AW-1:0];
	assign raddr  = cmd.rd_b ? addr_b : addr_a;

	// Word memory, one write and one registered read per cycle.
	assign we    = cmd.clear | (cmd.exec & we_x);
	assign waddr = cmd.clear ? clr_q : waddr_x;
	assign wdata = cmd.clear ? 16'd0 : wdata_x;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Divider operands are magnitudes; signs are fixed up afterward.
	assign is_rnd  = (opc_q == OP_RND);
	assign div_num = is_rnd ? {1'b0, rnd_q} : (rdata_q[15] ? -rdata_q : rdata_q);
	assign div_den = is_rnd ? (opd_q[15] ? -opd_q : opd_q) : (a_q[15] ? -a_q : a_q);

	sme_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.quo    (dq),
		.rem    (dr),
		.busy   (div_busy)
	);

	assign quo_s = (b_q[15] ^ a_q[15]) ? -dq : dq;
	assign rem_s = b_q[15] ? -dr : dr;
	assign prod  = b_q * a_q;

	// ALU: the top word is the right operand, the second word the left one.
	always_comb begin
		case (opd_q[3:0])
			ALU_EQ:  alu_res = {15'd0, b_q == a_q};
			ALU_NE:  alu_res = {15'd0, b_q != a_q};
			ALU_GE:  alu_res = {15'd0, $signed(b_q) >= $signed(a_q)};
			ALU_LE:  alu_res = {15'd0, $signed(b_q) <= $signed(a_q)};
			ALU_GT:  alu_res = {15'd0, $signed(b_q) > $signed(a_q)};
			ALU_LT:  alu_res = {15'd0, $signed(b_q) < $signed(a_q)};
			ALU_OR:  alu_res = b_q | a_q;
			ALU_XOR: alu_res = b_q ^ a_q;
			ALU_AND: alu_res = b_q & a_q;
			ALU_NOT: alu_res = ~a_q;
			ALU_ADD: alu_res = b_q + a_q;
			ALU_SUB: alu_res = b_q - a_q;
			ALU_MUL: alu_res = prod[15:0];
			ALU_DIV: alu_res = quo_s;
			ALU_MOD: alu_res = rem_s;
			default: alu_res = -a_q;
		endcase
	end

	// Checks on addresses, stack depth and program end.
	assign opd_ok  = !opd_q[15] && ({1'b0, opd_q} < MEMW);
	assign top_ok  = !a_q[15] && ({1'b0, a_q} < MEMW);
	assign sp_zero = (sp_q == '0);
	assign sp_le1  = (sp_q <= SPW'(1));
	assign sp_full = (17'(sp_q) == MEMW);
	assign running = !stopped_q && (pc_q < {5'd0, plen});
	assign pc_inc  = pc_q + 16'd1;
	assign pc_rel  = pc_inc + opd_q;

	// Execute one instruction: status, memory write, write output, stack pointer and pc.
	always_comb begin
		st      = STAT_OK;
		we_x    = 1'b0;
		waddr_x = sp_q[AW-1:0];
		wdata_x = a_q;
		sp_n    = sp_q;
		pc_n    = pc_q;
		wv      = 1'b0;
		wval    = 16'd0;
		if (stopped_q) begin
			st = held_q;
		end else if (running) begin
			pc_n = pc_inc;
			case (opc_q)
				OP_POP: begin
					if (sp_zero) st = STAT_EMPTY;
					else if (!opd_ok) st = STAT_ADDR;
					else begin
						we_x = 1'b1; waddr_x = opd_q[AW-1:0]; wdata_x = a_q; sp_n = sp_m1;
					end
				end
				OP_IPOP: begin
					if (sp_le1) st = STAT_EMPTY;
					else if (!top_ok) st = STAT_ADDR;
					else begin
						we_x = 1'b1; waddr_x = a_q[AW-1:0]; wdata_x = b_q; sp_n = sp_m2;
					end
				end
				OP_PUSH: begin
					if (sp_full) st = STAT_FULL;
					else if (!opd_ok) st = STAT_ADDR;
					else begin
						we_x = 1'b1; wdata_x = a_q; sp_n = sp_q + SPW'(1);
					end
				end
				OP_IPUSH: begin
					if (sp_zero) st = STAT_EMPTY;
					else if (!top_ok) st = STAT_ADDR;
					else begin
						we_x = 1'b1; waddr_x = sp_m1[AW-1:0]; wdata_x = b_q;
					end
				end
				OP_PUSHI: begin
					if (sp_full) st = STAT_FULL;
					else begin
						we_x = 1'b1; wdata_x = opd_q; sp_n = sp_q + SPW'(1);
					end
				end
				OP_JMP: pc_n = pc_rel;
				OP_JNZ: begin
					if (sp_zero) st = STAT_EMPTY;
					else begin
						if (a_q != 16'd0) pc_n = pc_rel;
						sp_n = sp_m1;
					end
				end
				OP_CALL: begin
					if (sp_full) st = STAT_FULL;
					else begin
						we_x = 1'b1; wdata_x = pc_inc; sp_n = sp_q + SPW'(1); pc_n = pc_rel;
					end
				end
				OP_RET: begin
					if (sp_zero) st = STAT_EMPTY;
					else begin
						pc_n = a_q; sp_n = sp_m1;
					end
				end
				OP_READ: begin
					if (!opd_ok) st = STAT_ADDR;
					else begin
						we_x = 1'b1; waddr_x = opd_q[AW-1:0]; wdata_x = rdv_q;
					end
				end
				OP_WRITE: begin
					if (!opd_ok) st = STAT_ADDR;
					else begin
						wv = 1'b1; wval = a_q;
					end
				end
				OP_ALU: begin
					if (opd_q == 16'(ALU_NOT) || opd_q == 16'(ALU_NEG)) begin
						if (sp_zero) st = STAT_EMPTY;
						else begin
							we_x = 1'b1; waddr_x = sp_m1[AW-1:0]; wdata_x = alu_res;
						end
					end else if (opd_q[15:4] != 12'd0) begin
						st = STAT_OPC;
					end else if (sp_le1) begin
						st = STAT_EMPTY;
					end else if ((opd_q[3:0] == ALU_DIV || opd_q[3:0] == ALU_MOD)
							&& a_q == 16'd0) begin
						st = STAT_DIV0;
					end else begin
						we_x = 1'b1; waddr_x = sp_m2[AW-1:0]; wdata_x = alu_res; sp_n = sp_m1;
					end
				end
				OP_RND: begin
					if (sp_full) st = STAT_FULL;
					else if (opd_q == 16'd0) st = STAT_DIV0;
					else begin
						we_x = 1'b1; wdata_x = dr; sp_n = sp_q + SPW'(1);
					end
				end
				OP_DUP: begin
					if (sp_full) st = STAT_FULL;
					else if (sp_zero) st = STAT_EMPTY;
					else begin
						we_x = 1'b1; wdata_x = a_q; sp_n = sp_q + SPW'(1);
					end
				end
				OP_NOP:  st = STAT_OK;
				OP_HALT: st = STAT_HALT;
				default: st = STAT_OPC;
			endcase
		end
	end

	// Architectural state and the memory clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
			held_q    <= STAT_OK;
			clr_q     <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + AW'(1);
			if (cmd.exec) begin
				sp_q <= sp_n;
				pc_q <= pc_n;
				if (st != STAT_OK) begin
					stopped_q <= 1'b1;
					held_q    <= st;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q.next_pc     <= pc_n;
			out_q.status      <= st;
			out_q.write_valid <= wv;
			out_q.write_value <= wval;
			out_q.finished    <= (pc_n >= {5'd0, plen});
		end
	end

	assign out_data        = out_q;
	assign stat.clear_last = (clr_q == AW'(MEM_WORDS - 1));
	assign stat.div_need   = is_rnd || (opc_q == OP_ALU
		&& (opd_q == 16'(ALU_DIV) || opd_q == 16'(ALU_MOD)));
	assign stat.div_busy   = div_busy;

endmodule

// ===== sv/stack_machine_execute.sv =====
// An accepted item goes through RDA, RDB, CAPB, DIV (div, mod and rnd only)
// and EXEC, which retires it once the output register is free. One item at a
// time; the single memory read port (two dependent reads per item) and the
// 16-step divider set the pace. Reset: arst_n clears stack pointer, pc, stop
// flag and program_length, then clearing zeroes memory while in_stall stays high.
module stack_machine_execute import sme_pkg::*; #(
	parameter int MEM_WORDS  = MEM_WORDS_DEF,
	parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  instr_t      in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [10:0] plen_q;
	ctrl_cmd_t   cmd;
	dp_stat_t    stat;

	// Program length register, saturated to the program store depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			if (17'(pwdata[10:0]) > 17'(PROG_DEPTH)) plen_q <= 11'(PROG_DEPTH);
			else plen_q <= pwdata[10:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {21'd0, plen_q} : 32'd0;

	sme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sme_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.plen     (plen_q),
		.out_data (out_data)
	);

endmodule

// ===== sv/sme_chk.sv =====
module sme_chk import sme_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_stall,
	input logic    out_valid,
	input logic    out_stall,
	input result_t out_data
);

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// One item at a time: after an accept the input side stalls.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while busy");

	// A written value appears only on a good step.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.write_valid |-> out_data.status == STAT_OK)
		else $error("write output with error status");

	// Without a write, the value is zero.
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_valid |-> out_data.write_value == 16'sd0)
		else $error("write value not zero");

endmodule

bind stack_machine_execute sme_chk u_sme_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== tb/stack_machine_execute_tb.sv =====
module stack_machine_execute_tb;
	import sme_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEMW      = MEM_WORDS_DEF;
	localparam int PDEPTH    = PROG_DEPTH_DEF;
	localparam int MAX_CYCLE = 1000000;

	typedef struct {
		instr_t  ins;
		result_t res;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	instr_t      in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	result_t     out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	stack_machine_execute u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Machine state as the testbench expects it to be.
	logic [15:0] mach_mem [MEMW];
	int          mach_sp;
	logic [15:0] mach_pc;
	bit          mach_stopped;
	status_t     mach_held;
	int          prog_len;

	stim_t   pending[$];
	result_t exp_results[$];
	stim_t   stim;
	result_t cur_res;
	int      errors = 0;
	int      results_seen = 0;
	int      cycles = 0;
	int      burst_left = 0;
	int      gap_left = 0;
	int      hold_left = 0;
	bit      held_once = 0;

	function automatic int sx16(logic [15:0] w);
		return int'($signed(w));
	endfunction

	function automatic bit addr_ok(int a);
		return a >= 0 && a < MEMW;
	endfunction

	// Executes one ALU operation on the top of the stack.
	function automatic status_t alu_exec(int code);
		int a, b, r;
		if (code == int'(ALU_NOT) || code == int'(ALU_NEG)) begin
			if (mach_sp == 0) return STAT_EMPTY;
			a = sx16(mach_mem[mach_sp - 1]);
			r = (code == int'(ALU_NOT)) ? ~a : -a;
			mach_mem[mach_sp - 1] = 16'(r);
			return STAT_OK;
		end
		if (code < 0 || code > 15) return STAT_OPC;
		if (mach_sp <= 1) return STAT_EMPTY;
		b = sx16(mach_mem[mach_sp - 1]);
		a = sx16(mach_mem[mach_sp - 2]);
		case (code)
			int'(ALU_EQ):  r = int'(a == b);
			int'(ALU_NE):  r = int'(a != b);
			int'(ALU_GE):  r = int'(a >= b);
			int'(ALU_LE):  r = int'(a <= b);
			int'(ALU_GT):  r = int'(a > b);
			int'(ALU_LT):  r = int'(a < b);
			int'(ALU_OR):  r = a | b;
			int'(ALU_XOR): r = a ^ b;
			int'(ALU_AND): r = a & b;
			int'(ALU_ADD): r = a + b;
			int'(ALU_SUB): r = a - b;
			int'(ALU_MUL): r = a * b;
			int'(ALU_DIV): begin
				if (b == 0) return STAT_DIV0;
				r = a / b;
			end
			default: begin
				if (b == 0) return STAT_DIV0;
				r = a % b;
			end
		endcase
		mach_sp--;
		mach_mem[mach_sp - 1] = 16'(r);
		return STAT_OK;
	endfunction

	// Runs one instruction on the expected machine state and returns its result.
	function automatic result_t exec_instr(instr_t it);
		result_t     r;
		status_t     st;
		bit          wv;
		logic [15:0] wval;
		int          opd, a, mag;
		st = STAT_OK;
		wv = 1'b0;
		wval = '0;
		opd = int'(it.instr_operand);
		if (mach_stopped) begin
			st = mach_held;
		end else if (int'(mach_pc) < prog_len) begin
			mach_pc = mach_pc + 16'd1;
			case (it.instr_opcode)
				OP_POP: begin
					if (mach_sp == 0) st = STAT_EMPTY;
					else if (!addr_ok(opd)) st = STAT_ADDR;
					else begin
						mach_mem[opd] = mach_mem[mach_sp - 1];
						mach_sp--;
					end
				end
				OP_IPOP: begin
					if (mach_sp <= 1) st = STAT_EMPTY;
					else begin
						a = sx16(mach_mem[mach_sp - 1]);
						if (!addr_ok(a)) st = STAT_ADDR;
						else begin
							mach_mem[a] = mach_mem[mach_sp - 2];
							mach_sp -= 2;
						end
					end
				end
				OP_PUSH: begin
					if (mach_sp >= MEMW) st = STAT_FULL;
					else if (!addr_ok(opd)) st = STAT_ADDR;
					else begin
						mach_mem[mach_sp] = mach_mem[opd];
						mach_sp++;
					end
				end
				OP_IPUSH: begin
					if (mach_sp == 0) st = STAT_EMPTY;
					else begin
						a = sx16(mach_mem[mach_sp - 1]);
						if (!addr_ok(a)) st = STAT_ADDR;
						else mach_mem[mach_sp - 1] = mach_mem[a];
					end
				end
				OP_PUSHI: begin
					if (mach_sp >= MEMW) st = STAT_FULL;
					else begin
						mach_mem[mach_sp] = 16'(opd);
						mach_sp++;
					end
				end
				OP_JMP: mach_pc = mach_pc + 16'(opd);
				OP_JNZ: begin
					if (mach_sp == 0) st = STAT_EMPTY;
					else begin
						if (mach_mem[mach_sp - 1] != 16'd0) mach_pc = mach_pc + 16'(opd);
						mach_sp--;
					end
				end
				OP_CALL: begin
					if (mach_sp >= MEMW) st = STAT_FULL;
					else begin
						mach_mem[mach_sp] = mach_pc;
						mach_sp++;
						mach_pc = mach_pc + 16'(opd);
					end
				end
				OP_RET: begin
					if (mach_sp == 0) st = STAT_EMPTY;
					else begin
						mach_pc = mach_mem[mach_sp - 1];
						mach_sp--;
					end
				end
				OP_READ: begin
					if (!addr_ok(opd)) st = STAT_ADDR;
					else mach_mem[opd] = it.read_value;
				end
				OP_WRITE: begin
					if (!addr_ok(opd)) st = STAT_ADDR;
					else begin
						wv = 1'b1;
						wval = mach_mem[opd];
					end
				end
				OP_ALU: st = alu_exec(opd);
				OP_RND: begin
					if (mach_sp >= MEMW) st = STAT_FULL;
					else if (opd == 0) st = STAT_DIV0;
					else begin
						mag = (opd < 0) ? -opd : opd;
						mach_mem[mach_sp] = 16'(int'(it.random_value) % mag);
						mach_sp++;
					end
				end
				OP_DUP: begin
					if (mach_sp >= MEMW) st = STAT_FULL;
					else if (mach_sp == 0) st = STAT_EMPTY;
					else begin
						mach_mem[mach_sp] = mach_mem[mach_sp - 1];
						mach_sp++;
					end
				end
				OP_NOP: ;
				OP_HALT: st = STAT_HALT;
				default: st = STAT_OPC;
			endcase
			if (st != STAT_OK) begin
				mach_stopped = 1'b1;
				mach_held = st;
			end
		end
		r.next_pc = mach_pc;
		r.status = st;
		r.write_valid = wv;
		r.write_value = wval;
		r.finished = (int'(mach_pc) >= prog_len);
		return r;
	endfunction

	// Queues one item together with the result it is expected to give.
	task automatic emit(logic [6:0] op, int opd);
		stim_t s;
		s.ins.instr_opcode = op;
		s.ins.instr_operand = 16'(opd);
		s.ins.read_value = 16'($urandom);
		s.ins.random_value = 15'($urandom);
		s.res = exec_instr(s.ins);
		pending.push_back(s);
	endtask

	// Item with every field random, used where the block ignores it.
	task automatic emit_any();
		emit(7'($urandom), int'($urandom));
	endtask

	function automatic int val16();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return sx16(16'($urandom));
		endcase
	endfunction

	function automatic int pick_addr();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return MEMW - 1;
			2: return $urandom_range(0, MEMW - 1);
			default: return $urandom_range(0, 63);
		endcase
	endfunction

	// Relative offset that lands the program counter on the given target.
	function automatic int offset_to(int target);
		return sx16(16'(target - (int'(mach_pc) + 1)));
	endfunction

	function automatic int low_target();
		return $urandom_range(0, prog_len - 12);
	endfunction

	// Jumps back before the program runs out, so execution goes on.
	task automatic keep_running();
		if (prog_len > 20 && int'(mach_pc) >= prog_len - 8)
			emit(OP_JMP, offset_to(low_target()));
	endtask

	// One well-formed instruction, with whatever setup it needs to succeed.
	task automatic gen_step();
		int k, code;
		keep_running();
		k = (mach_sp > 200) ? 0 : $urandom_range(0, 15);
		case (k)
			0: begin
				if (mach_sp == 0) emit(OP_PUSHI, val16());
				emit(OP_POP, pick_addr());
			end
			1: begin
				if (mach_sp == 0) emit(OP_PUSHI, val16());
				emit(OP_PUSHI, pick_addr());
				emit(OP_IPOP, val16());
			end
			2: emit(OP_PUSH, pick_addr());
			3: begin
				emit(OP_PUSHI, pick_addr());
				emit(OP_IPUSH, val16());
			end
			4: emit(OP_PUSHI, val16());
			5: emit(OP_JMP, offset_to(low_target()));
			6: begin
				if (mach_sp == 0 || $urandom_range(0, 1))
					emit(OP_PUSHI, $urandom_range(0, 1) ? 0 : val16());
				emit(OP_JNZ, offset_to(low_target()));
			end
			7: emit(OP_CALL, offset_to(low_target()));
			8: begin
				emit(OP_PUSHI, low_target());
				emit(OP_RET, val16());
			end
			9: emit(OP_READ, pick_addr());
			10: emit(OP_WRITE, pick_addr());
			11, 12: begin
				code = $urandom_range(0, 15);
				if (mach_sp < 2 || $urandom_range(0, 1)) begin
					emit(OP_PUSHI, val16());
					emit(OP_PUSHI, val16());
				end
				if ((code == int'(ALU_DIV) || code == int'(ALU_MOD)) &&
				    mach_mem[mach_sp - 1] == 16'd0)
					emit(OP_PUSHI, $urandom_range(0, 1) ? -1 : $urandom_range(1, 32767));
				emit(OP_ALU, code);
			end
			13: begin
				code = val16();
				emit(OP_RND, (code == 0) ? 1 : code);
			end
			14: begin
				if (mach_sp == 0) emit(OP_PUSHI, val16());
				emit(OP_DUP, val16());
			end
			default: emit(OP_NOP, val16());
		endcase
	endtask

	// Register write through the APB port, with the matching state update.
	task automatic set_length(int value);
		int v;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 2'd0;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		v = value & 32'h7ff;
		prog_len = (v > PDEPTH) ? PDEPTH : v;
	endtask

	task automatic wait_drained();
		while (pending.size() > 0 || in_valid || exp_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Sender: bursts of items separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) exp_results.push_back(cur_res);
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending.size() > 0) begin
				stim = pending.pop_front();
				in_valid <= 1'b1;
				in_data <= stim.ins;
				cur_res = stim.res;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern that steps through four stall densities, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!held_once && results_seen >= 400) begin
			held_once <= 1'b1;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else begin
			case ((cycles / 64) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	task automatic report(string field, int want, int got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	// Compares each delivered result item with the oldest expected one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (exp_results.size() == 0) begin
				$display("%0t: unexpected result item, actual %0h", $time, out_data);
				errors++;
			end else begin
				want = exp_results.pop_front();
				if (out_data.next_pc !== want.next_pc)
					report("next_pc", want.next_pc, out_data.next_pc);
				if (out_data.status !== want.status)
					report("status", want.status, out_data.status);
				if (out_data.write_valid !== want.write_valid)
					report("write_valid", want.write_valid, out_data.write_valid);
				if (out_data.write_value !== want.write_value)
					report("write_value", want.write_value, out_data.write_value);
				if (out_data.finished !== want.finished)
					report("finished", want.finished, out_data.finished);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("stack_machine_execute_tb failed");
			$finish;
		end
	end

	initial begin
		int kind;
		foreach (mach_mem[i]) mach_mem[i] = '0;
		mach_sp = 0;
		mach_pc = '0;
		mach_stopped = 1'b0;
		mach_held = STAT_OK;
		prog_len = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The memory clearing pass holds the input off until it is done.
		while (in_stall) @(posedge clk);

		// Empty program: every item is ignored and reported as finished.
		set_length(0);
		repeat (6) emit_any();
		wait_drained();

		// One instruction, then the program is over.
		set_length(1);
		emit(OP_PUSHI, val16());
		repeat (4) emit_any();
		wait_drained();

		// Written above the program store size, so the length saturates.
		set_length(2047);
		emit(OP_PUSHI, -32768);
		emit(OP_PUSHI, -1);
		emit(OP_ALU, ALU_DIV);
		emit(OP_PUSHI, -1);
		emit(OP_ALU, ALU_MOD);
		emit(OP_PUSHI, 32767);
		emit(OP_ALU, ALU_NEG);
		emit(OP_DUP, 0);
		emit(OP_ALU, ALU_NOT);
		emit(OP_READ, MEMW - 1);
		emit(OP_WRITE, MEMW - 1);
		emit(OP_PUSH, MEMW - 1);
		emit(OP_POP, 0);
		emit(OP_PUSHI, MEMW - 1);
		emit(OP_IPUSH, 0);
		emit(OP_PUSHI, 0);
		emit(OP_IPOP, 0);
		emit(OP_RND, -32768);
		emit(OP_RND, 32767);
		emit(OP_RND, 1);
		emit(OP_NOP, 0);
		emit(OP_JNZ, 0);
		emit(OP_CALL, 1);
		emit(OP_RET, 0);
		emit(OP_JMP, 0);
		repeat (600) gen_step();
		emit(OP_JMP, offset_to(5));
		wait_drained();

		// Shorter program; it ends by jumping exactly to its length.
		set_length($urandom_range(300, 700));
		repeat (500) gen_step();
		keep_running();
		emit(OP_JMP, offset_to(prog_len));
		repeat (4) emit_any();
		wait_drained();

		// Longest program, closing with one error or a halt that stops the block.
		set_length(PDEPTH);
		repeat (100) gen_step();
		keep_running();
		kind = $urandom_range(0, 5);
		case (kind)
			0: emit(OP_HALT, val16());
			1: begin
				while (mach_sp > 0) begin
					keep_running();
					emit(OP_POP, pick_addr());
				end
				keep_running();
				emit($urandom_range(0, 1) ? OP_POP : OP_RET, 0);
			end
			2: emit($urandom_range(0, 1) ? OP_READ : OP_WRITE,
			        $urandom_range(0, 1) ? $urandom_range(MEMW, 32767) : -$urandom_range(1, 32768));
			3: begin
				if ($urandom_range(0, 1)) begin
					emit(OP_RND, 0);
				end else begin
					emit(OP_PUSHI, val16());
					emit(OP_PUSHI, 0);
					emit(OP_ALU, $urandom_range(0, 1) ? ALU_DIV : ALU_MOD);
				end
			end
			4: emit($urandom_range(0, 1) ? $urandom_range(14, 97) : $urandom_range(100, 127),
			        val16());
			default: begin
				emit(OP_PUSHI, val16());
				emit(OP_PUSHI, val16());
				emit(OP_ALU, $urandom_range(0, 1) ? $urandom_range(16, 32767)
				                                  : -$urandom_range(1, 32768));
			end
		endcase
		// The block now only repeats the status that stopped it.
		repeat (8) emit_any();
		wait_drained();

		if (errors == 0) begin
			$display("stack_machine_execute_tb passed");
		end else begin
			$display("stack_machine_execute_tb failed");
		end
		$finish;
	end

endmodule

// ===== stack_machine_execute.f =====
sv/sme_pkg.sv
sv/sme_div.sv
sv/sme_ctrl.sv
sv/sme_dp.sv
sv/stack_machine_execute.sv
sv/sme_chk.sv
tb/stack_machine_execute_tb.sv
